FILE: hdl/rgb2hwb_pkg.sv
// ----------------------------------------------------------------------------
// rgb2hwb_pkg
// Shared widths, sector codes and beat types for the rgb to hwb converter.
// ----------------------------------------------------------------------------
package rgb2hwb_pkg;

  localparam int unsigned CHANNEL_BITS      = 8;
  localparam int unsigned HUE_FRACTION_BITS = 8;
  localparam int unsigned HUE_BITS          = HUE_FRACTION_BITS + 3;

  // quotient of |diff| * 2^F / span never exceeds 2^F
  localparam int unsigned QUOT_BITS     = HUE_FRACTION_BITS + 1;
  localparam int unsigned REM_BITS      = CHANNEL_BITS + 1;
  localparam int unsigned DIV_STEPS     = 2;
  localparam int unsigned DIV_STAGES    = (QUOT_BITS + DIV_STEPS - 1) / DIV_STEPS;
  // front stage, sector stage, divider stages, output stage
  localparam int unsigned NUM_STAGES    = DIV_STAGES + 3;
  localparam int unsigned SECTOR_BITS   = 3;

  localparam logic [SECTOR_BITS-1:0] SECTOR_RED_MIN   = SECTOR_BITS'(3);
  localparam logic [SECTOR_BITS-1:0] SECTOR_GREEN_MIN = SECTOR_BITS'(5);
  localparam logic [SECTOR_BITS-1:0] SECTOR_BLUE_MIN  = SECTOR_BITS'(1);

  localparam logic [CHANNEL_BITS-1:0] CHAN_MAX = '1;

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] red;
    logic [CHANNEL_BITS-1:0] green;
    logic [CHANNEL_BITS-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [HUE_BITS-1:0]     hue;
    logic [CHANNEL_BITS-1:0] whiteness;
    logic [CHANNEL_BITS-1:0] blackness;
    logic                    hue_undefined;
  } hwb_t;

  // min and max found, channels carried along
  typedef struct packed {
    pixel_t                  pix;
    logic [CHANNEL_BITS-1:0] lo;
    logic [CHANNEL_BITS-1:0] hi;
  } front_t;

  // state carried through the divider
  typedef struct packed {
    logic [REM_BITS-1:0]     rem;
    logic [QUOT_BITS-1:0]    quot;
    logic [CHANNEL_BITS-1:0] span;
    logic                    neg;
    logic [SECTOR_BITS-1:0]  base;
    logic [CHANNEL_BITS-1:0] lo;
    logic [CHANNEL_BITS-1:0] hi;
    logic                    undef;
  } div_t;

endpackage

FILE: hdl/rgb_to_hwb_pixel_convert.sv
// ----------------------------------------------------------------------------
// rgb_to_hwb_pixel_convert
// Pipelined rgb to hue / whiteness / blackness pixel converter.
// ----------------------------------------------------------------------------
// Usage:
//   input channel  valid_i / ready_o / pixel_i : one rgb pixel per beat
//   output channel valid_o / ready_i / hwb_o   : one hwb result per beat
//   Every input beat yields exactly one output beat, in order.
//   The pipeline is NUM_STAGES stages deep: a min/max stage,
//   a sector stage, DIV_STAGES restoring divider stages that each resolve
//   up to two quotient bits of |diff| * 2^F / span, and an output register.
//   Throughput is one pixel per cycle while ready_i is high; each stage
//   holds a valid bit and takes a new beat whenever it is empty or its
//   successor moves, so bubbles are squeezed out while the receiver stalls
//   and ready_o only drops once every stage is full.
//   Reset clears all valid bits; no beat is in flight afterwards.
//   Grey pixels give hue 0 with hue_undefined set.
// ----------------------------------------------------------------------------
module rgb_to_hwb_pixel_convert
  import rgb2hwb_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   valid_i,
  output logic   ready_o,
  input  pixel_t pixel_i,
  output logic   valid_o,
  input  logic   ready_i,
  output hwb_t   hwb_o
);

  localparam int unsigned LAST = NUM_STAGES - 1;

  logic [NUM_STAGES-1:0] valid_q;
  logic [NUM_STAGES-1:0] stage_rdy;

  // a stage may load when it is empty or its content moves on
  always_comb begin
    stage_rdy[LAST] = !valid_q[LAST] || ready_i;
    for (int k = int'(LAST) - 1; k >= 0; k--) begin
      stage_rdy[k] = !valid_q[k] || stage_rdy[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (stage_rdy[0]) begin
        valid_q[0] <= valid_i;
      end
      for (int k = 1; k < int'(NUM_STAGES); k++) begin
        if (stage_rdy[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  assign ready_o = stage_rdy[0];
  assign valid_o = valid_q[LAST];

  // front stage: min and max
  front_t front_d, front_q;

  always_comb begin
    front_d.pix = pixel_i;
    front_d.lo  = pixel_i.red;
    front_d.hi  = pixel_i.red;
    if (pixel_i.green < front_d.lo) front_d.lo = pixel_i.green;
    if (pixel_i.blue  < front_d.lo) front_d.lo = pixel_i.blue;
    if (pixel_i.green > front_d.hi) front_d.hi = pixel_i.green;
    if (pixel_i.blue  > front_d.hi) front_d.hi = pixel_i.blue;
  end

  always_ff @(posedge clk_i) begin
    if (stage_rdy[0] && valid_i) begin
      front_q <= front_d;
    end
  end

  // sector stage: pick base and signed difference, first minimum wins
  div_t sect_d, sect_q;
  logic [CHANNEL_BITS-1:0] dif_a, dif_b;

  always_comb begin
    priority if (front_q.pix.red == front_q.lo) begin
      dif_a       = front_q.pix.green;
      dif_b       = front_q.pix.blue;
      sect_d.base = SECTOR_RED_MIN;
    end else if (front_q.pix.green == front_q.lo) begin
      dif_a       = front_q.pix.blue;
      dif_b       = front_q.pix.red;
      sect_d.base = SECTOR_GREEN_MIN;
    end else begin
      dif_a       = front_q.pix.red;
      dif_b       = front_q.pix.green;
      sect_d.base = SECTOR_BLUE_MIN;
    end
    sect_d.neg   = dif_a < dif_b;
    sect_d.rem   = sect_d.neg ? REM_BITS'(dif_b - dif_a) : REM_BITS'(dif_a - dif_b);
    sect_d.quot  = '0;
    sect_d.span  = front_q.hi - front_q.lo;
    sect_d.lo    = front_q.lo;
    sect_d.hi    = front_q.hi;
    sect_d.undef = front_q.hi == front_q.lo;
  end

  always_ff @(posedge clk_i) begin
    if (stage_rdy[1] && valid_q[0]) begin
      sect_q <= sect_d;
    end
  end

  // restoring divider, up to DIV_STEPS quotient bits per stage
  div_t div_q [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    div_t div_src, div_nxt;

    assign div_src = (s == 0) ? sect_q : div_q[(s == 0) ? 0 : s - 1];

    always_comb begin
      div_nxt = div_src;
      for (int j = 0; j < int'(DIV_STEPS); j++) begin
        if (s * DIV_STEPS + j < QUOT_BITS) begin
          if (div_nxt.rem >= {1'b0, div_nxt.span}) begin
            div_nxt.quot = {div_nxt.quot[QUOT_BITS-2:0], 1'b1};
            div_nxt.rem  = (div_nxt.rem - {1'b0, div_nxt.span}) << 1;
          end else begin
            div_nxt.quot = {div_nxt.quot[QUOT_BITS-2:0], 1'b0};
            div_nxt.rem  = div_nxt.rem << 1;
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (stage_rdy[s+2] && valid_q[s+1]) begin
        div_q[s] <= div_nxt;
      end
    end
  end

  // output stage: hue = base * 2^F - signed quotient, or 0 when hue is undefined
  div_t div_last;
  logic [HUE_BITS-1:0] base_ext, quot_ext;
  hwb_t hwb_d, hwb_q;

  assign div_last = div_q[DIV_STAGES-1];

  always_comb begin
    base_ext = {div_last.base, {HUE_FRACTION_BITS{1'b0}}};
    quot_ext = HUE_BITS'(div_last.quot);
    if (div_last.undef) begin
      hwb_d.hue = '0;
    end else if (div_last.neg) begin
      hwb_d.hue = base_ext + quot_ext;
    end else begin
      hwb_d.hue = base_ext - quot_ext;
    end
    hwb_d.whiteness     = div_last.lo;
    hwb_d.blackness     = CHAN_MAX - div_last.hi;
    hwb_d.hue_undefined = div_last.undef;
  end

  always_ff @(posedge clk_i) begin
    if (stage_rdy[LAST] && valid_q[LAST-1]) begin
      hwb_q <= hwb_d;
    end
  end

  assign hwb_o = hwb_q;

endmodule
